@@ design/abpsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Annex B parameter-set filter package
// Shared types and constants for the front parser, the job queue and the
// result sequencer.
// ----------------------------------------------------------------------------
package abpsf_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [1:0] PH_SEEK   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  localparam logic       CODEC_H264 = 1'b0;
  localparam logic       CODEC_H265 = 1'b1;

  localparam logic [5:0] H264_SPS = 6'd7;
  localparam logic [5:0] H264_PPS = 6'd8;
  localparam logic [5:0] H265_VPS = 6'd32;
  localparam logic [5:0] H265_SPS = 6'd33;
  localparam logic [5:0] H265_PPS = 6'd34;

  // One input byte's worth of results: zeros, then 01, then the byte,
  // then the frame-end marker, each part optional.
  typedef struct packed {
    logic [2:0] zeros;
    logic       first;
    logic       one;
    logic       has_byte;
    logic [7:0] data;
    logic [5:0] nal_type;
    logic       marker;
    logic       end_on_byte;
  } job_t;

  localparam int JobWidth = $bits(job_t);

  typedef struct packed {
    logic       frame_end;
    logic       nal_first;
    logic [5:0] nal_type;
    logic       byte_valid;
  } out_user_t;

endpackage

@@ design/abpsf_front.sv @@
// ----------------------------------------------------------------------------
// Annex B front parser
// Tracks start codes and NAL headers one byte per cycle while in_fire is high, and
// turns each byte that causes results into a job that describes the results it causes.
// ----------------------------------------------------------------------------
module abpsf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               in_fire,
  input  logic [7:0]         data_byte,
  input  logic               frame_last,
  output logic               job_push,
  output abpsf_pkg::job_t    job
);
  import abpsf_pkg::*;

  logic       codec_select;
  logic [1:0] zero_run, zero_run_next;
  logic [1:0] phase, phase_next;
  logic       code_is_long, code_is_long_next;
  logic       keep, keep_next;
  logic [5:0] cur_type, cur_type_next;

  logic [5:0] hdr_type;
  logic       hdr_keep;
  logic       body;

  always_comb begin
    if (codec_select == CODEC_H265) begin
      hdr_type = data_byte[6:1];
      hdr_keep = (hdr_type == H265_VPS) || (hdr_type == H265_SPS) ||
                 (hdr_type == H265_PPS);
    end else begin
      hdr_type = {1'b0, data_byte[4:0]};
      hdr_keep = (hdr_type == H264_SPS) || (hdr_type == H264_PPS);
    end
  end

  assign body = (phase == PH_BODY);

  always_comb begin
    zero_run_next     = zero_run;
    phase_next        = phase;
    code_is_long_next = code_is_long;
    keep_next         = keep;
    cur_type_next     = cur_type;
    job               = '0;
    job.data          = data_byte;
    job.nal_type      = cur_type;

    if (phase == PH_HEADER) begin
      cur_type_next     = hdr_type;
      keep_next         = hdr_keep;
      phase_next        = PH_BODY;
      zero_run_next     = 2'd0;
      code_is_long_next = 1'b0;
      job.nal_type      = hdr_type;
      if (hdr_keep) begin
        job.zeros    = code_is_long ? 3'd3 : 3'd2;
        job.first    = 1'b1;
        job.one      = 1'b1;
        job.has_byte = 1'b1;
      end
    end else if (data_byte == 8'd0) begin
      if (zero_run != 2'd3) begin
        zero_run_next = zero_run + 2'd1;
      end else if (body && keep) begin
        job.zeros = 3'd1;
      end
    end else if (data_byte == 8'd1 && zero_run[1]) begin
      code_is_long_next = (zero_run == 2'd3);
      zero_run_next     = 2'd0;
      phase_next        = PH_HEADER;
    end else begin
      if (body && keep) begin
        job.zeros    = {1'b0, zero_run};
        job.has_byte = 1'b1;
      end
      zero_run_next = 2'd0;
    end

    if (frame_last) begin
      // Held zeros belong to the current unit when the frame closes.
      if (phase_next == PH_BODY && keep_next) begin
        job.zeros = job.zeros + {1'b0, zero_run_next};
      end
      // A kept header after a long start code already fills all five slots.
      if (phase == PH_HEADER && hdr_keep && code_is_long) begin
        job.end_on_byte = 1'b1;
      end else begin
        job.marker = 1'b1;
      end
      zero_run_next     = 2'd0;
      phase_next        = PH_SEEK;
      code_is_long_next = 1'b0;
      keep_next         = 1'b0;
      cur_type_next     = 6'd0;
    end
  end

  assign job_push = in_fire && ((job.zeros != 3'd0) || job.one || job.has_byte ||
                                job.marker);

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_select <= CODEC_H264;
      zero_run     <= 2'd0;
      phase        <= PH_SEEK;
      code_is_long <= 1'b0;
      keep         <= 1'b0;
      cur_type     <= 6'd0;
    end else begin
      if (cfg_we) begin
        codec_select <= cfg_data;
      end
      if (in_fire) begin
        zero_run     <= zero_run_next;
        phase        <= phase_next;
        code_is_long <= code_is_long_next;
        keep         <= keep_next;
        cur_type     <= cur_type_next;
      end
    end
  end

endmodule

@@ design/abpsf_queue.sv @@
// ----------------------------------------------------------------------------
// Job queue
// Small FIFO of jobs between the front parser and the result sequencer.
// ----------------------------------------------------------------------------
module abpsf_queue #(
  parameter int Depth = abpsf_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  abpsf_pkg::job_t    push_job,
  input  logic               pop,
  output abpsf_pkg::job_t    head_job,
  output logic               not_empty,
  output logic               full
);
  import abpsf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CntW'(Depth));
  assign head_job  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/abpsf_back.sv @@
// ----------------------------------------------------------------------------
// Result sequencer
// Holds one job and steps out its results, one per output transaction.
// ----------------------------------------------------------------------------
module abpsf_back (
  input  logic               clk,
  input  logic               rst,
  input  abpsf_pkg::job_t    head_job,
  input  logic               head_valid,
  output logic               pop,
  output logic               m_valid,
  input  logic               m_ready,
  output logic [7:0]         m_data,
  output abpsf_pkg::out_user_t m_user,
  output logic               m_last
);
  import abpsf_pkg::*;

  logic       busy;
  job_t       cur;
  logic [2:0] remaining;
  logic       fire;
  logic       done;

  assign remaining = cur.zeros + {2'b00, cur.one} + {2'b00, cur.has_byte} +
                     {2'b00, cur.marker};
  assign m_valid = busy;
  assign m_last  = (remaining == 3'd1);
  assign fire    = busy && m_ready;
  assign done    = fire && m_last;
  assign pop     = head_valid && (!busy || done);

  always_comb begin
    m_data = 8'd0;
    m_user = '0;
    if (cur.zeros != 3'd0) begin
      m_user.byte_valid = 1'b1;
      m_user.nal_type   = cur.nal_type;
      m_user.nal_first  = cur.first;
    end else if (cur.one) begin
      m_data            = 8'd1;
      m_user.byte_valid = 1'b1;
      m_user.nal_type   = cur.nal_type;
    end else if (cur.has_byte) begin
      m_data            = cur.data;
      m_user.byte_valid = 1'b1;
      m_user.nal_type   = cur.nal_type;
      m_user.frame_end  = cur.end_on_byte;
    end else begin
      m_user.frame_end  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end else if (fire) begin
      if (cur.zeros != 3'd0) begin
        cur.zeros <= cur.zeros - 3'd1;
        cur.first <= 1'b0;
      end else if (cur.one) begin
        cur.one <= 1'b0;
      end else if (cur.has_byte) begin
        cur.has_byte <= 1'b0;
      end else begin
        cur.marker <= 1'b0;
      end
    end
  end

endmodule

@@ design/annexb_parameter_set_filter.sv @@
// A byte's results pass through the job queue and then the sequencer's job register
// before the first of them is driven on the output.
// Throughput: one input byte per cycle while the output keeps up; the output stage
// sends one result per cycle while m_tready is high, so a byte causing several results
// holds it for each of them. The job queue absorbs bursts of up to QUEUE_DEPTH bytes.
// Reset (rst, synchronous): parser state cleared, queue emptied, codec set to H.264.
// ----------------------------------------------------------------------------
// Annex B parameter-set filter
// Forwards the bytes of H.264/H.265 parameter-set NAL units from an Annex B
// byte stream, start code included, and marks each frame end.
// ----------------------------------------------------------------------------
module annexb_parameter_set_filter #(
  parameter int QUEUE_DEPTH = abpsf_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,       // codec_select
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,        // data_byte
  input  logic       s_tlast,        // frame_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,        // out_byte
  output logic [8:0] m_tuser,        // byte_valid, nal_type[5:0], nal_first, frame_end
  output logic       m_tlast         // run_last
);
  import abpsf_pkg::*;

  job_t      push_job;
  job_t      head_job;
  logic      push;
  logic      pop;
  logic      not_empty;
  logic      full;
  logic      in_fire;
  out_user_t user;

  assign s_tready = !full;
  assign in_fire  = s_tvalid && s_tready;
  assign m_tuser  = user;

  abpsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .data_byte  (s_tdata),
    .frame_last (s_tlast),
    .job_push   (push),
    .job        (push_job)
  );

  abpsf_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (not_empty),
    .full      (full)
  );

  abpsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (not_empty),
    .pop        (pop),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_data     (m_tdata),
    .m_user     (user),
    .m_last     (m_tlast)
  );

  // A frame-end flag always closes the run of results of its byte.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && user.frame_end |-> m_tlast)
    else $error("frame end not on last result");

  // The marker result carries no byte and always ends the frame.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !user.byte_valid |-> user.frame_end && m_tdata == 8'd0)
    else $error("marker result malformed");

  // A unit always opens on a zero byte of a kept type.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && user.nal_first |-> m_tdata == 8'd0 && user.byte_valid)
    else $error("first byte of unit is not a start-code zero");

  // A frame-last byte always leaves a job in the queue.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tlast |-> push)
    else $error("frame end lost");

endmodule
